// ===== hdl/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Line follower PD steering package
// Shared request types, maneuver codes, the error map and the checkpoint
// schedule of the steering block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

	// Widths of the request fields.
	localparam int unsigned LINE_W  = 5;
	localparam int unsigned DIST_W  = 9;
	localparam int unsigned SPEED_W = 8;
	localparam int unsigned MAN_W   = 3;
	localparam int unsigned CP_W    = 3;
	localparam int unsigned ERR_W   = 4;
	localparam int unsigned GP_W    = 5;
	localparam int unsigned GD_W    = 4;

	// Reset values of the configuration and the tuning state.
	localparam logic [DIST_W-1:0]  START_DIST_RESET = 9'd15;
	localparam logic [SPEED_W-1:0] BASE_RESET       = 8'd130;
	localparam logic [GP_W-1:0]    GAIN_P_RESET     = 5'd20;
	localparam logic [GD_W-1:0]    GAIN_D_RESET     = 4'd10;
	localparam logic [CP_W-1:0]    CP_LAST          = 3'd5;
	localparam logic [SPEED_W-1:0] SPEED_MAX        = 8'd255;

	// Sensor patterns for checkpoints and fixed maneuvers.
	localparam logic [LINE_W-1:0] PAT_ALL_BLACK  = 5'b11111;
	localparam logic [LINE_W-1:0] PAT_TURN_RIGHT = 5'b01111;
	localparam logic [LINE_W-1:0] PAT_TURN_LEFT  = 5'b11110;
	localparam logic [LINE_W-1:0] PAT_WHITE_MASK = 5'b10101;
	localparam logic [LINE_W-1:0] PAT_WHITE_VAL  = 5'b10001;

	typedef enum logic [MAN_W-1:0] {
		MAN_WAIT       = 3'd0,
		MAN_LAUNCH     = 3'd1,
		MAN_PD         = 3'd2,
		MAN_WHITE      = 3'd3,
		MAN_TURN_RIGHT = 3'd4,
		MAN_TURN_LEFT  = 3'd5
	} maneuver_t;

	typedef struct packed {
		logic [LINE_W-1:0] line_bits;
		logic [DIST_W-1:0] distance_cm;
	} line_req_t;

	typedef struct packed {
		logic [SPEED_W-1:0] left_speed;
		logic [SPEED_W-1:0] right_speed;
		maneuver_t          maneuver;
		logic [CP_W-1:0]    checkpoints_passed;
	} drive_req_t;

	typedef struct packed {
		logic [SPEED_W-1:0] base;
		logic [GP_W-1:0]    gain_p;
		logic [GD_W-1:0]    gain_d;
	} gains_t;

	typedef struct packed {
		logic                    hit;
		logic signed [ERR_W-1:0] value;
	} err_map_t;

	// Maps a sensor pattern to a steering error; a miss clears the hit flag so the last error is held.
	function automatic err_map_t map_error(input logic [LINE_W-1:0] bits);
		err_map_t r;
		r.hit   = 1'b1;
		r.value = 4'sd0;
		case (bits)
			5'b00000: r.value = 4'sd0;
			5'b11111: r.value = 4'sd0;
			5'b01110: r.value = 4'sd0;
			5'b00110: r.value = 4'sd1;
			5'b01100: r.value = -4'sd1;
			5'b00111: r.value = 4'sd2;
			5'b11100: r.value = -4'sd2;
			5'b00011: r.value = 4'sd3;
			5'b11000: r.value = -4'sd3;
			5'b00001: r.value = 4'sd4;
			5'b10000: r.value = -4'sd4;
			default:  r.hit   = 1'b0;
		endcase
		return r;
	endfunction

	// Base speed and gains loaded when a checkpoint is crossed.
	function automatic gains_t checkpoint_gains(input logic [CP_W-1:0] idx);
		gains_t g;
		case (idx)
			3'd0:    g = '{base: 8'd80,  gain_p: 5'd10, gain_d: 4'd5};
			3'd1:    g = '{base: 8'd100, gain_p: 5'd25, gain_d: 4'd10};
			3'd2:    g = '{base: 8'd130, gain_p: 5'd20, gain_d: 4'd10};
			3'd3:    g = '{base: 8'd80,  gain_p: 5'd10, gain_d: 4'd5};
			default: g = '{base: 8'd130, gain_p: 5'd20, gain_d: 4'd10};
		endcase
		return g;
	endfunction

endpackage

// ===== hdl/line_follow_pd_steering.sv =====
// ----------------------------------------------------------------------------
// Line follower PD steering
// Turns each sensor sample into two wheel duties and a maneuver code, with a
// start gate, a checkpoint gain schedule and fixed turn maneuvers.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// line      in         line_valid/line_ready   line_req_t (line_bits, distance_cm)
// drive     out        drive_valid/drive_ready drive_req_t (speeds, maneuver, count)
// cfg       in         cfg_valid/cfg_ready     start distance, 9 bits
//
// One sample per cycle sustained while the drive side does not stall. A sample
// accepted into the input register moves into the result register once that
// register can advance, and its drive request is then valid.
// The controller state is updated as a sample moves into the result register.
// A stalled drive request holds the result register and a full input register
// behind it; an empty input register still takes one sample. cfg_ready is
// always high.
// Reset clears the start gate, errors and checkpoint index and restores the
// default base speed, gains and start distance.
module line_follow_pd_steering (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   line_valid,
	output logic                   line_ready,
	input  lfpd_pkg::line_req_t    line_req,
	output logic                   drive_valid,
	input  logic                   drive_ready,
	output lfpd_pkg::drive_req_t   drive_req,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [8:0]             cfg_data
);
	import lfpd_pkg::*;

	logic                    s1_valid_q;
	line_req_t               req_s1;
	logic                    drive_valid_q;
	drive_req_t              drive_q;
	logic                    advance;
	logic                    fire;

	logic [DIST_W-1:0]       start_dist_q;
	logic                    running_q;
	logic signed [ERR_W-1:0] cur_err_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic [CP_W-1:0]         cp_idx_q;
	gains_t                  gains_q;

	err_map_t                emap;
	logic                    cp_step;
	gains_t                  gains_new;
	logic [CP_W-1:0]         cp_idx_new;
	logic signed [ERR_W-1:0] e_new;
	logic signed [ERR_W:0]   e_diff;
	logic signed [9:0]       p_term;
	logic signed [9:0]       d_term;
	logic signed [10:0]      pd_sum;
	logic signed [11:0]      left_sum;
	logic signed [11:0]      right_sum;
	logic                    launch;
	drive_req_t              drive_new;

	// Handshake: the input register refills whenever its content moves on.
	assign advance     = !drive_valid_q || drive_ready;
	assign fire        = s1_valid_q && advance;
	assign line_ready  = !s1_valid_q || advance;
	assign drive_valid = drive_valid_q;
	assign drive_req   = drive_q;
	assign cfg_ready   = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (line_ready) begin
			s1_valid_q <= line_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_ready && line_valid) begin
			req_s1 <= line_req;
		end
	end

	// Start distance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_dist_q <= START_DIST_RESET;
		end else if (cfg_valid) begin
			start_dist_q <= cfg_data;
		end
	end

	// Error map and checkpoint schedule; new gains apply on the same sample.
	always_comb begin
		emap       = map_error(req_s1.line_bits);
		cp_step    = (req_s1.line_bits == PAT_ALL_BLACK) && (cp_idx_q != CP_LAST);
		gains_new  = cp_step ? checkpoint_gains(cp_idx_q) : gains_q;
		cp_idx_new = cp_step ? cp_idx_q + 3'd1 : cp_idx_q;
		e_new      = emap.hit ? emap.value : cur_err_q;
		launch     = !running_q && (req_s1.distance_cm > start_dist_q);
	end

	// PD term and clamped wheel sums.
	always_comb begin
		e_diff    = {e_new[ERR_W-1], e_new} - {prev_err_q[ERR_W-1], prev_err_q};
		p_term    = $signed({5'b0, gains_new.gain_p}) *
			$signed({{6{e_new[ERR_W-1]}}, e_new});
		d_term    = $signed({6'b0, gains_new.gain_d}) *
			$signed({{5{e_diff[ERR_W]}}, e_diff});
		pd_sum    = {p_term[9], p_term} + {d_term[9], d_term};
		left_sum  = $signed({4'b0, gains_new.base}) + {pd_sum[10], pd_sum};
		right_sum = $signed({4'b0, gains_new.base}) - {pd_sum[10], pd_sum};
	end

	// Result selection.
	always_comb begin
		drive_new                    = '0;
		drive_new.maneuver           = MAN_WAIT;
		drive_new.checkpoints_passed = cp_idx_q;
		if (!running_q) begin
			if (launch) begin
				drive_new.left_speed  = gains_q.base;
				drive_new.right_speed = gains_q.base;
				drive_new.maneuver    = MAN_LAUNCH;
			end
		end else begin
			drive_new.checkpoints_passed = cp_idx_new;
			if ((req_s1.line_bits & PAT_WHITE_MASK) == PAT_WHITE_VAL) begin
				drive_new.left_speed  = gains_new.base;
				drive_new.right_speed = gains_new.base;
				drive_new.maneuver    = MAN_WHITE;
			end else if (req_s1.line_bits == PAT_TURN_RIGHT) begin
				drive_new.left_speed  = gains_new.base;
				drive_new.maneuver    = MAN_TURN_RIGHT;
			end else if (req_s1.line_bits == PAT_TURN_LEFT) begin
				drive_new.right_speed = gains_new.base;
				drive_new.maneuver    = MAN_TURN_LEFT;
			end else begin
				if (left_sum[11]) begin
					drive_new.left_speed = '0;
				end else if (left_sum[10:8] != 3'd0) begin
					drive_new.left_speed = SPEED_MAX;
				end else begin
					drive_new.left_speed = left_sum[7:0];
				end
				if (right_sum[11]) begin
					drive_new.right_speed = '0;
				end else if (right_sum[10:8] != 3'd0) begin
					drive_new.right_speed = SPEED_MAX;
				end else begin
					drive_new.right_speed = right_sum[7:0];
				end
				drive_new.maneuver = MAN_PD;
			end
		end
	end

	// Controller state, updated as a sample is retired.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			cur_err_q  <= '0;
			prev_err_q <= '0;
			cp_idx_q   <= '0;
			gains_q    <= '{base: BASE_RESET, gain_p: GAIN_P_RESET, gain_d: GAIN_D_RESET};
		end else if (fire) begin
			if (!running_q) begin
				running_q <= launch;
			end else begin
				cur_err_q  <= e_new;
				prev_err_q <= e_new;
				cp_idx_q   <= cp_idx_new;
				gains_q    <= gains_new;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
		end else if (advance) begin
			drive_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			drive_q <= drive_new;
		end
	end

	// The checkpoint index saturates at the last schedule entry.
	assert property (@(posedge clk) disable iff (!arst_n) cp_idx_q <= CP_LAST)
		else $error("checkpoint index beyond schedule");

	// Once started, the controller never returns to the start gate.
	assert property (@(posedge clk) disable iff (!arst_n) running_q |=> running_q)
		else $error("start gate reopened");

	// Starting always coincides with a launch request being loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(running_q) |-> drive_valid_q && drive_q.maneuver == MAN_LAUNCH)
		else $error("start without launch request");

	// A waiting request drives both wheels at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid_q && drive_q.maneuver == MAN_WAIT |->
		drive_q.left_speed == '0 && drive_q.right_speed == '0)
		else $error("wheels moving while waiting");

	// The held error stays within the sensor map.
	assert property (@(posedge clk) disable iff (!arst_n)
		cur_err_q >= -4'sd4 && cur_err_q <= 4'sd4)
		else $error("steering error out of range");

endmodule

// ===== dv/line_follow_pd_steering_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line follower PD steering testbench
// Drives sensor samples through the start gate, launch and steering phases.
// A scoreboard predicts each drive request and compares it field by field.
// Four pressure phases vary sender gaps and receiver stalls, and the start
// distance is rewritten between phases.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_tb;
	import lfpd_pkg::*;

	// Predicts drive requests from accepted sensor samples and checks the block.
	class steering_scoreboard;
		logic [DIST_W-1:0]       start_dist;
		bit                      running;
		logic signed [ERR_W-1:0] err_now;
		logic signed [ERR_W-1:0] err_last;
		logic [CP_W-1:0]         cp_idx;
		logic [SPEED_W-1:0]      base;
		logic [GP_W-1:0]         kp;
		logic [GD_W-1:0]         kd;
		drive_req_t              expected_q[$];
		int                      n_samples;
		int                      n_checked;
		int                      n_errors;

		function new();
			start_dist = START_DIST_RESET;
			running    = 1'b0;
			err_now    = '0;
			err_last   = '0;
			cp_idx     = '0;
			base       = BASE_RESET;
			kp         = GAIN_P_RESET;
			kd         = GAIN_D_RESET;
			n_samples  = 0;
			n_checked  = 0;
			n_errors   = 0;
		endfunction

		function void set_start_distance(logic [DIST_W-1:0] v);
			start_dist = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [SPEED_W-1:0] clamp_duty(int v);
			if (v > 255) return SPEED_MAX;
			if (v < 0) return '0;
			return v[SPEED_W-1:0];
		endfunction

		// Works out the drive request that one accepted sample causes.
		function void note_sample(line_req_t s);
			drive_req_t d;
			int e;
			int m;
			d = '0;
			d.maneuver = MAN_WAIT;
			n_samples++;
			if (!running) begin
				if (s.distance_cm > start_dist) begin
					running = 1'b1;
					d.left_speed  = base;
					d.right_speed = base;
					d.maneuver    = MAN_LAUNCH;
				end
			end else begin
				case (s.line_bits)
					5'b00000, 5'b01110: err_now = 4'sd0;
					PAT_ALL_BLACK: begin
						// Crossing a checkpoint loads the next base speed and gains.
						case (cp_idx)
							3'd0, 3'd3: {base, kp, kd} = {8'd80, 5'd10, 4'd5};
							3'd1:       {base, kp, kd} = {8'd100, 5'd25, 4'd10};
							3'd2, 3'd4: {base, kp, kd} = {8'd130, 5'd20, 4'd10};
							default: ;
						endcase
						if (cp_idx < CP_LAST) cp_idx++;
						err_now = 4'sd0;
					end
					5'b00110: err_now = 4'sd1;
					5'b01100: err_now = -4'sd1;
					5'b00111: err_now = 4'sd2;
					5'b11100: err_now = -4'sd2;
					5'b00011: err_now = 4'sd3;
					5'b11000: err_now = -4'sd3;
					5'b00001: err_now = 4'sd4;
					5'b10000: err_now = -4'sd4;
					default: ;
				endcase
				e = err_now;
				m = int'(kp) * e + int'(kd) * (e - err_last);
				err_last = err_now;

				// Fixed maneuvers take priority over the PD result.
				if ((s.line_bits & PAT_WHITE_MASK) == PAT_WHITE_VAL) begin
					d.left_speed  = base;
					d.right_speed = base;
					d.maneuver    = MAN_WHITE;
				end else if (s.line_bits == PAT_TURN_RIGHT) begin
					d.left_speed = base;
					d.maneuver   = MAN_TURN_RIGHT;
				end else if (s.line_bits == PAT_TURN_LEFT) begin
					d.right_speed = base;
					d.maneuver    = MAN_TURN_LEFT;
				end else begin
					d.left_speed  = clamp_duty(int'(base) + m);
					d.right_speed = clamp_duty(int'(base) - m);
					d.maneuver    = MAN_PD;
				end
			end
			d.checkpoints_passed = cp_idx;
			expected_q.push_back(d);
		endfunction

		// Compares one accepted drive request with the oldest prediction.
		function void check_drive(drive_req_t got);
			drive_req_t want;
			if (expected_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%0t: drive request with none expected: %p", $realtime, got);
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			if (got.left_speed !== want.left_speed || got.right_speed !== want.right_speed ||
					got.maneuver !== want.maneuver ||
					got.checkpoints_passed !== want.checkpoints_passed) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%0t: drive request %0d mismatch: expected %p, got %p",
						$realtime, n_checked, want, got);
			end
		endfunction
	endclass

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              line_valid  = 1'b0;
	logic              line_ready;
	line_req_t         line_req    = '0;
	logic              drive_valid;
	logic              drive_ready = 1'b0;
	drive_req_t        drive_req;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [DIST_W-1:0] cfg_data    = '0;

	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	steering_scoreboard sb             = new();

	localparam logic [LINE_W-1:0] STEER_PATS [10] = '{
		5'b00000, 5'b01110, 5'b00110, 5'b01100, 5'b00111,
		5'b11100, 5'b00011, 5'b11000, 5'b00001, 5'b10000
	};

	line_follow_pd_steering uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_valid  (line_valid),
		.line_ready  (line_ready),
		.line_req    (line_req),
		.drive_valid (drive_valid),
		.drive_ready (drive_ready),
		.drive_req   (drive_req),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver side: check accepted requests and stall at random.
	always @(posedge clk) begin
		if (arst_n && drive_valid && drive_ready) sb.check_drive(drive_req);
		drive_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Presents one sample, with an optional random gap, and waits for acceptance.
	task automatic send_sample(input logic [LINE_W-1:0] bits,
		input logic [DIST_W-1:0] distance);
		line_req_t s;
		s.line_bits   = bits;
		s.distance_cm = distance;
		if ($urandom_range(99) < send_idle_pct) begin
			line_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		line_valid <= 1'b1;
		line_req   <= s;
		do @(posedge clk); while (!line_ready);
		sb.note_sample(s);
	endtask

	// Stops the sample stream and waits until every request has come back.
	task automatic drain();
		line_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_start_distance(input logic [DIST_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_start_distance(v);
	endtask

	// Mostly mapped steering patterns, with rare checkpoints, maneuvers and noise.
	task automatic send_random_sample();
		int r;
		logic [LINE_W-1:0] bits;
		r = $urandom_range(999);
		if (r < 10)
			bits = PAT_ALL_BLACK;
		else if (r < 700)
			bits = STEER_PATS[$urandom_range(9)];
		else if (r < 740)
			bits = PAT_TURN_RIGHT;
		else if (r < 780)
			bits = PAT_TURN_LEFT;
		else if (r < 820)
			bits = PAT_WHITE_VAL | (5'($urandom) & ~PAT_WHITE_MASK);
		else
			bits = 5'($urandom);
		send_sample(bits, 9'($urandom_range(511)));
	endtask

	initial begin
		#2_000_000;
		$display("line_follow_pd_steering verification failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start gate with the reset threshold, then with thresholds of 0 and 400.
		send_sample(5'b00000, 9'd0);
		send_sample(5'b11111, 9'd15);
		drain();
		write_start_distance(9'd0);
		send_sample(5'b00001, 9'd0);
		drain();
		write_start_distance(9'd400);
		send_sample(5'b10000, 9'd400);
		send_sample(5'b01110, 9'd300);
		// A distance beyond the threshold launches the robot.
		send_sample(5'b10101, 9'd511);

		// Every mapped error, a held error, the maneuvers and clamping at both ends.
		send_sample(5'b00000, 9'($urandom));
		send_sample(5'b00110, 9'($urandom));
		send_sample(5'b01100, 9'($urandom));
		send_sample(5'b00111, 9'($urandom));
		send_sample(5'b11100, 9'($urandom));
		send_sample(5'b00011, 9'($urandom));
		send_sample(5'b11000, 9'($urandom));
		send_sample(5'b10000, 9'($urandom));
		send_sample(5'b00001, 9'($urandom));
		send_sample(5'b01010, 9'($urandom));
		send_sample(5'b01110, 9'($urandom));
		send_sample(5'b10001, 9'($urandom));
		send_sample(5'b11011, 9'($urandom));
		send_sample(PAT_TURN_RIGHT, 9'($urandom));
		send_sample(PAT_TURN_LEFT, 9'($urandom));
		send_sample(PAT_ALL_BLACK, 9'($urandom));
		send_sample(5'b10000, 9'($urandom));
		send_sample(5'b00001, 9'($urandom));

		// Random part in four pressure phases, with a new threshold between them.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			if (ph != 0) begin
				drain();
				case (ph)
					1: write_start_distance(9'($urandom_range(400)));
					2: write_start_distance(9'd0);
					default: write_start_distance(9'd400);
				endcase
			end
			repeat (220) send_random_sample();
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d sensor samples and checked %0d drive requests across four pressure phases;",
			sb.n_samples, sb.n_checked);
		$display("checkpoint index reached %0d, mismatches %0d.", sb.cp_idx, sb.n_errors);
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("line_follow_pd_steering verification clean");
		else
			$display("line_follow_pd_steering verification failed");
		$finish;
	end

endmodule
